// ===== sv/mh32_pkg.sv =====
// ----------------------------------------------------------------------------
// mh32_pkg
// Shared types and constants for the streaming 32-bit message hash.
// ----------------------------------------------------------------------------
package mh32_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // byte position inside a 4-byte group
    localparam logic [1:0] POS_B0 = 2'd0;
    localparam logic [1:0] POS_B1 = 2'd1;
    localparam logic [1:0] POS_B2 = 2'd2;
    localparam logic [1:0] POS_B3 = 2'd3;

    typedef struct packed {
        logic        first;
        logic        last;
        logic [1:0]  pos;
        logic [7:0]  data;
        logic [15:0] half;
        logic [31:0] seed;
    } t_item;

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// ===== sv/mh32_front.sv =====
// ----------------------------------------------------------------------------
// mh32_front
// Accepts message bytes, counts them and tags each item with its group
// position, start and end of message, and the 16-bit half it completes.
// ----------------------------------------------------------------------------
module mh32_front #(
    parameter int LENGTH_BITS = mh32_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic [LENGTH_BITS-1:0] i_message_length,
    input  logic                   i_full,
    output logic                   o_push,
    output mh32_pkg::t_item        o_item
);

    logic [LENGTH_BITS-1:0] r_count;
    logic [LENGTH_BITS-1:0] n_count;
    logic [7:0]             r_prev;
    logic [LENGTH_BITS:0]   count_inc;
    logic                   last;

    assign o_ready   = !i_full;
    assign o_push    = i_valid && o_ready;
    assign count_inc = {1'b0, r_count} + {{LENGTH_BITS{1'b0}}, 1'b1};
    assign last      = count_inc >= {1'b0, i_message_length};
    assign n_count   = last ? '0 : count_inc[LENGTH_BITS-1:0];

    always_comb begin
        o_item.first = (r_count == '0);
        o_item.last  = last;
        o_item.pos   = r_count[1:0];
        o_item.data  = i_data_byte;
        o_item.half  = {i_data_byte, r_prev};
        o_item.seed  = 32'(i_message_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev <= i_data_byte;
        end
    end

endmodule

// ===== sv/mh32_queue.sv =====
// ----------------------------------------------------------------------------
// mh32_queue
// Short register queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mh32_queue #(
    parameter int DEPTH = mh32_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mh32_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mh32_pkg::t_item o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    mh32_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== sv/mh32_back.sv =====
// ----------------------------------------------------------------------------
// mh32_back
// Folds items into the running hash, at most one add per byte, and finishes a
// message through a stalling pipeline: tail mix, then three avalanche steps.
// ----------------------------------------------------------------------------
module mh32_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mh32_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_hash_value
);

    localparam int NSTG = 6;

    typedef struct packed {
        logic [31:0] c;
        logic [1:0]  pos;
        logic [7:0]  tb;
    } t_fin;

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic t_fin stage_fn(input logic [2:0] k, input t_fin s);
        t_fin        r;
        logic [31:0] c;
        logic [31:0] t;
        r = s;
        c = s.c;
        t = '0;
        case (k)
            3'd1: begin
                if (s.pos == mh32_pkg::POS_B0) begin
                    c = c + mh32_pkg::sext8(s.tb);
                end
            end
            3'd2: begin
                case (s.pos)
                    mh32_pkg::POS_B0: begin
                        c = c ^ (c << 10);
                        c = c + asr(c, 1);
                    end
                    mh32_pkg::POS_B1: begin
                        c = c ^ (c << 11);
                        c = c + asr(c, 17);
                    end
                    mh32_pkg::POS_B2: begin
                        t = (mh32_pkg::sext8(s.tb) << 2) ^ c;
                        c = c ^ (t << 16);
                        c = c + asr(c, 11);
                    end
                    default: begin
                        c = s.c;
                    end
                endcase
            end
            3'd3: begin
                c = c ^ (c << 3);
                c = c + asr(c, 5);
            end
            3'd4: begin
                c = c ^ (c << 4);
                c = c + asr(c, 17);
            end
            3'd5: begin
                c = c ^ (c << 25);
                c = c + asr(c, 6);
            end
            default: begin
                c = s.c;
            end
        endcase
        r.c = c;
        return r;
    endfunction

    logic [31:0] r_hash;
    logic [31:0] base;
    logic [31:0] hi;
    logic [31:0] grp;
    logic [31:0] n_hash;
    t_fin        r_s   [NSTG];
    t_fin        n_s   [NSTG];
    logic        r_v   [NSTG];
    logic        rdy   [NSTG+1];

    // running hash update, at most one add per byte
    always_comb begin
        base = i_item.first ? i_item.seed : r_hash;
        hi   = (mh32_pkg::sext16(i_item.half) ^ (base << 5)) << 11;
        grp  = base ^ hi;
        case (i_item.pos)
            mh32_pkg::POS_B1: begin
                n_hash = base + mh32_pkg::sext16(i_item.half);
            end
            mh32_pkg::POS_B3: begin
                n_hash = grp + asr(grp, 11);
            end
            default: begin
                n_hash = base;
            end
        endcase
    end

    always_comb begin
        rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_pop = i_valid && (!i_item.last || rdy[0]);

    always_comb begin
        n_s[0].c   = n_hash;
        n_s[0].pos = i_item.pos;
        n_s[0].tb  = i_item.data;
        for (int k = 1; k < NSTG; k++) begin
            n_s[k] = stage_fn(3'(k), r_s[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_item.last) begin
            r_hash <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid && i_item.last;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_valid      = r_v[NSTG-1];
    assign o_hash_value = r_s[NSTG-1].c;

endmodule

// ===== sv/message_hash_32.sv =====
// ----------------------------------------------------------------------------
// message_hash_32
// Streaming 32-bit hash of a byte message, one byte per item.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle unless stalled; the running hash takes at most one add a byte
// output: the hash of a message passes the item queue and then the finishing
//   pipeline, which holds it while the output is not taken
// reset: synchronous active-low i_rst_n clears the byte count, queue and
//   pipeline valids; the block is ready in the first cycle after reset
// ----------------------------------------------------------------------------
module message_hash_32 #(
    parameter int LENGTH_BITS = mh32_pkg::LENGTH_BITS_DEF,
    parameter int QDEPTH      = mh32_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic [LENGTH_BITS-1:0] i_message_length,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_hash_value
);

    mh32_pkg::t_item f_item;
    mh32_pkg::t_item q_item;
    logic            f_push;
    logic            q_full;
    logic            q_valid;
    logic            b_pop;

    mh32_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_full           (q_full),
        .o_push           (f_push),
        .o_item           (f_item)
    );

    mh32_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    mh32_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (b_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule

// ===== sim/message_hash_32_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_hash_32_chk
// Watches both channels of message_hash_32, keeps its own running hash of
// every accepted item and compares each hash that leaves the block, in order,
// against the value it predicted.
// ----------------------------------------------------------------------------
module message_hash_32_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic [mh32_pkg::LENGTH_BITS_DEF-1:0] i_message_length,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [31:0]                         i_hash_value,
    output int                                  o_error_count,
    output int                                  o_hashes_pending,
    output int                                  o_hashes_checked
);

    localparam int LEN_W = mh32_pkg::LENGTH_BITS_DEF;

    logic [31:0]      run_hash;
    logic [LEN_W-1:0] byte_count;
    logic [23:0]      held_bytes;
    logic [31:0]      expected_hashes[$];
    logic [31:0]      want_hash;
    int               error_total   = 0;
    int               checked_total = 0;
    int               pending_total = 0;

    assign o_error_count    = error_total;
    assign o_hashes_pending = pending_total;
    assign o_hashes_checked = checked_total;

    function automatic logic [31:0] shift_right_arith(input logic [31:0] v, input int s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    function automatic logic [31:0] mix_group(input logic [31:0] c_in, input logic [31:0] g);
        logic [31:0] c;
        logic [31:0] hi;
        c  = c_in + {{16{g[15]}}, g[15:0]};
        hi = {{16{g[31]}}, g[31:16]} ^ (c << 5);
        hi = hi << 11;
        c  = c ^ hi;
        c  = c + shift_right_arith(c, 11);
        return c;
    endfunction

    function automatic logic [31:0] mix_tail(input logic [31:0] c_in, input logic [23:0] p,
                                             input logic [1:0] n);
        logic [31:0] c;
        logic [31:0] t;
        c = c_in;
        case (n)
            mh32_pkg::POS_B3: begin
                c = c + {{16{p[15]}}, p[15:0]};
                t = ({{24{p[23]}}, p[23:16]} << 2) ^ c;
                c = c ^ (t << 16);
                c = c + shift_right_arith(c, 11);
            end
            mh32_pkg::POS_B2: begin
                c = c + {{16{p[15]}}, p[15:0]};
                c = c ^ (c << 11);
                c = c + shift_right_arith(c, 17);
            end
            mh32_pkg::POS_B1: begin
                c = c + {{24{p[7]}}, p[7:0]};
                c = c ^ (c << 10);
                c = c + shift_right_arith(c, 1);
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] c_in);
        logic [31:0] c;
        c = c_in;
        c = c ^ (c << 3);
        c = c + shift_right_arith(c, 5);
        c = c ^ (c << 4);
        c = c + shift_right_arith(c, 17);
        c = c ^ (c << 25);
        c = c + shift_right_arith(c, 6);
        return c;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        logic [31:0]  h;
        logic [LEN_W:0] count_next;
        logic [1:0]   pos;
        if (byte_count == '0) begin
            h = 32'(len);
        end else begin
            h = run_hash;
        end
        pos        = byte_count[1:0];
        count_next = {1'b0, byte_count} + (LEN_W+1)'(1);
        if (pos == mh32_pkg::POS_B3) begin
            h          = mix_group(h, {b, held_bytes});
            held_bytes = '0;
        end else begin
            held_bytes = held_bytes | ({16'b0, b} << (8 * pos));
        end
        if (count_next >= {1'b0, len}) begin
            h = avalanche(mix_tail(h, held_bytes, count_next[1:0]));
            expected_hashes.push_back(h);
            run_hash   = '0;
            byte_count = '0;
            held_bytes = '0;
        end else begin
            run_hash   = h;
            byte_count = count_next[LEN_W-1:0];
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_hash   = '0;
            byte_count = '0;
            held_bytes = '0;
            expected_hashes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value with no finished message: actual %08h", i_hash_value);
                    error_total++;
                end else begin
                    want_hash = expected_hashes.pop_front();
                    checked_total++;
                    if (want_hash !== i_hash_value) begin
                        $error("hash_value mismatch: expected %08h, actual %08h",
                               want_hash, i_hash_value);
                        error_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_byte(i_data_byte, i_message_length);
            end
        end
        pending_total = expected_hashes.size();
    end

endmodule

// ===== sim/message_hash_32_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_hash_32_tb
// Feeds message_hash_32 with directed edge-case messages and then random
// messages (well-formed, zero-length, length-changing and noisy), with random
// idling on both channels, one long output stall and one full drain pause.
// ----------------------------------------------------------------------------
module message_hash_32_tb;

    localparam int LEN_W          = mh32_pkg::LENGTH_BITS_DEF;
    localparam int ITEM_TARGET    = 1700;
    localparam int QUIET_ITEMS    = 150;
    localparam int RX_HOLD_AT     = 500;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TX_PAUSE_AT    = 900;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 300000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [7:0]       i_data_byte;
    logic [LEN_W-1:0] i_message_length;
    logic             o_valid;
    logic             i_ready;
    logic [31:0]      o_hash_value;

    int sent_count  = 0;
    int cycle_count = 0;
    int chk_errors;
    int chk_pending;
    int chk_checked;
    bit quiet        = 1'b0;
    bit rx_hold_done = 1'b0;
    bit tx_paused    = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    message_hash_32 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_message_length(i_message_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hash_value    (o_hash_value)
    );

    message_hash_32_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_data_byte     (i_data_byte),
        .i_message_length(i_message_length),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_hash_value    (o_hash_value),
        .o_error_count   (chk_errors),
        .o_hashes_pending(chk_pending),
        .o_hashes_checked(chk_checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offers one item until an edge accepts it; outside the quiet phase it may then drop valid before returning
    task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_message_length <= len;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        sent_count++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        while (chk_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // receiver side
    initial begin
        i_ready <= 1'b0;
        forever begin
            if (!rx_hold_done && sent_count >= RX_HOLD_AT) begin
                rx_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // sender side and verdict
    initial begin
        int kind;
        int msg_len;
        int n_bytes;
        int cnt;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= '0;
        i_message_length <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one message per tail size and a full group, byte extremes
        send_byte(8'h80, 1);
        send_byte(8'hFF, 2);
        send_byte(8'hFF, 2);
        send_byte(8'h7F, 3);
        send_byte(8'h80, 3);
        send_byte(8'hFF, 3);
        send_byte(8'h00, 4);
        send_byte(8'hFF, 4);
        send_byte(8'h80, 4);
        send_byte(8'h7F, 4);
        send_byte(8'hFF, 5);
        send_byte(8'hFF, 5);
        send_byte(8'hFF, 5);
        send_byte(8'hFF, 5);
        send_byte(8'h80, 5);
        // zero length ends on the first item
        send_byte(8'hFF, 0);
        // largest length seeds the hash, later item shortens the message
        send_byte(8'h55, 16'hFFFF);
        send_byte(8'hAA, 2);
        // length shrinks to the count already taken
        send_byte(8'h01, 3);
        send_byte(8'hFE, 1);

        while (sent_count < ITEM_TARGET) begin
            if (!tx_paused && sent_count >= TX_PAUSE_AT) begin
                tx_paused = 1'b1;
                i_valid <= 1'b0;
                wait_for_drain();
            end
            quiet = (sent_count >= ITEM_TARGET - QUIET_ITEMS);
            kind  = $urandom_range(0, 19);
            if (kind < 15) begin
                if ($urandom_range(0, 9) == 0) begin
                    msg_len = $urandom_range(13, 80);
                end else begin
                    msg_len = $urandom_range(1, 12);
                end
                repeat (msg_len) send_byte(8'($urandom_range(0, 255)), LEN_W'(msg_len));
            end else if (kind < 16) begin
                send_byte(8'($urandom_range(0, 255)), 0);
            end else if (kind < 18) begin
                cnt = 1;
                send_byte(8'($urandom_range(0, 255)), LEN_W'($urandom_range(2, 65535)));
                n_bytes = $urandom_range(0, 5);
                repeat (n_bytes) begin
                    cnt++;
                    send_byte(8'($urandom_range(0, 255)),
                              LEN_W'($urandom_range(cnt + 1, 65535)));
                end
                cnt++;
                send_byte(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, cnt)));
            end else begin
                // noise, then a zero-length item closes whatever is open
                n_bytes = $urandom_range(1, 4);
                repeat (n_bytes) begin
                    send_byte(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 65535)));
                end
                send_byte(8'($urandom_range(0, 255)), 0);
            end
        end
        send_byte(8'($urandom_range(0, 255)), 0);

        i_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d message bytes, checked %0d hashes", sent_count, chk_checked);
        $display("covered all tail sizes, zero and changing lengths, long stall, drain pause");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
